// ===== rtl/morse_key_pulse_width_transmitter_defines.svh =====
// Assertion macros for the Morse key pulse-width transmitter.
`ifndef MORSE_KEY_PULSE_WIDTH_TRANSMITTER_DEFINES_SVH
`define MORSE_KEY_PULSE_WIDTH_TRANSMITTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MKPWT_ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("invariant violated");
// Antecedent true implies consequent true in the same cycle.
`define MKPWT_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define MKPWT_ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop)
`define MKPWT_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

// ===== rtl/mkpwt_pkg.sv =====
package mkpwt_pkg;

    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int HELD_W     = 5;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [TIME_W-1:0]     time_t;
    typedef logic [DUTY_W-1:0]     duty_t;
    typedef logic [MS_W-1:0]       ms_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_DOT_MAX   = 3'd0;
    localparam cfg_idx_t REG_IDLE_GAP  = 3'd1;
    localparam cfg_idx_t REG_SYM_PER   = 3'd2;
    localparam cfg_idx_t REG_START     = 3'd3;
    localparam cfg_idx_t REG_DOT_CODE  = 3'd4;
    localparam cfg_idx_t REG_DASH_CODE = 3'd5;
    localparam cfg_idx_t REG_END_CODE  = 3'd6;
    localparam cfg_idx_t REG_EMPTY     = 3'd7;

    // Reset values of the configuration registers
    localparam ms_t   RST_DOT_MAX   = 16'd250;
    localparam ms_t   RST_IDLE_GAP  = 16'd1000;
    localparam ms_t   RST_SYM_PER   = 16'd50;
    localparam duty_t RST_START     = 8'd50;
    localparam duty_t RST_DOT_CODE  = 8'd150;
    localparam duty_t RST_DASH_CODE = 8'd200;
    localparam duty_t RST_END_CODE  = 8'd100;
    localparam duty_t RST_EMPTY     = 8'd250;

    localparam duty_t DUTY_OFF = 8'd0;

endpackage

// ===== rtl/morse_key_pulse_width_transmitter.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+--------------------------------------------
// in       | in_valid / in_ready      | button_pressed
// out      | out_valid / out_ready    | duty_value, duty_updated, busy_sending,
//          |                          | symbols_held
// cfg      | cfg_we (no wait)         | cfg_index, cfg_data
//
// One word in, one word out, one cycle per word: the whole tick update is a
// single pass of logic from the accepted word into the state and result registers.
// A new word is taken every cycle while the result register is empty or drained.
// Stalls on out_ready back up into in_ready through the single result register.
// Asynchronous active-low reset returns the tick state and out_valid to zero and
// the configuration registers to their documented defaults; the result payload is not reset.

`include "morse_key_pulse_width_transmitter_defines.svh"

module morse_key_pulse_width_transmitter
    import mkpwt_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  button_pressed,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DUTY_W-1:0]     duty_value,
    output logic                  duty_updated,
    output logic                  busy_sending,
    output logic [HELD_W-1:0]     symbols_held,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Count holds 0..MAX_SYMBOLS; position runs one past the count for the end code.
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int POS_W = $clog2(MAX_SYMBOLS + 2);
    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    typedef logic [MAX_SYMBOLS-1:0] sym_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [POS_W-1:0]       pos_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ms_t   dot_max_reg;
    ms_t   idle_gap_reg;
    ms_t   sym_per_reg;
    duty_t start_code_reg;
    duty_t dot_code_reg;
    duty_t dash_code_reg;
    duty_t end_code_reg;
    duty_t empty_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_max_reg    <= RST_DOT_MAX;
            idle_gap_reg   <= RST_IDLE_GAP;
            sym_per_reg    <= RST_SYM_PER;
            start_code_reg <= RST_START;
            dot_code_reg   <= RST_DOT_CODE;
            dash_code_reg  <= RST_DASH_CODE;
            end_code_reg   <= RST_END_CODE;
            empty_code_reg <= RST_EMPTY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DOT_MAX:   dot_max_reg    <= cfg_data;
                REG_IDLE_GAP:  idle_gap_reg   <= cfg_data;
                REG_SYM_PER:   sym_per_reg    <= cfg_data;
                REG_START:     start_code_reg <= cfg_data[DUTY_W-1:0];
                REG_DOT_CODE:  dot_code_reg   <= cfg_data[DUTY_W-1:0];
                REG_DASH_CODE: dash_code_reg  <= cfg_data[DUTY_W-1:0];
                REG_END_CODE:  end_code_reg   <= cfg_data[DUTY_W-1:0];
                REG_EMPTY:     empty_code_reg <= cfg_data[DUTY_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tick state
    // ------------------------------------------------------------------
    time_t tick_reg,       tick_next;
    time_t press_reg,      press_next;
    time_t release_reg,    release_next;
    time_t last_send_reg,  last_send_next;
    logic  key_down_reg,   key_down_next;
    sym_t  bits_reg,       bits_next;
    cnt_t  count_reg,      count_next;
    pos_t  pos_reg,        pos_next;
    logic  sending_reg,    sending_next;
    logic  gap_reg,        gap_next;
    duty_t duty_reg,       duty_next;
    logic  updated_next;

    // Result register
    logic  out_valid_reg,  out_valid_next;
    duty_t res_duty_reg;
    logic  res_upd_reg;
    logic  res_busy_reg;
    cnt_t  res_held_reg;

    logic  accept;
    time_t held;
    logic  is_dash;
    pos_t  count_ext;
    pos_t  sh_full;
    logic  cur_bit;

    // Hold the result until taken; accept alongside a draining result.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        tick_next      = tick_reg + TIME_W'(1);
        press_next     = press_reg;
        release_next   = release_reg;
        last_send_next = last_send_reg;
        key_down_next  = key_down_reg;
        bits_next      = bits_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        sending_next   = sending_reg;
        gap_next       = gap_reg;
        duty_next      = duty_reg;
        updated_next   = 1'b0;

        held    = tick_next - press_reg;
        is_dash = held > TIME_W'(dot_max_reg);

        // Key edges: note the press, classify on release.
        if (button_pressed && !key_down_reg)
        begin
            key_down_next = 1'b1;
            press_next    = tick_next;
        end
        else if (!button_pressed && key_down_reg)
        begin
            key_down_next = 1'b0;
            release_next  = tick_next;
            if (count_reg < CNT_W'(MAX_SYMBOLS))
            begin
                bits_next  = (bits_reg << 1) | sym_t'(is_dash);
                count_next = count_reg + CNT_W'(1);
            end
        end

        // Oldest symbol sits at the top of the held run.
        count_ext = POS_W'(count_next);
        sh_full   = count_ext - pos_reg - POS_W'(1);
        cur_bit   = bits_next[sh_full[IDX_W-1:0]];

        // Frame sequencer: start after the idle gap, then one update per period.
        if ((count_next != '0) && !sending_reg)
        begin
            if ((tick_next - release_next) >= TIME_W'(idle_gap_reg))
            begin
                sending_next   = 1'b1;
                pos_next       = '0;
                duty_next      = start_code_reg;
                updated_next   = 1'b1;
                last_send_next = tick_next;
            end
        end
        else if (sending_reg)
        begin
            if ((tick_next - last_send_reg) >= TIME_W'(sym_per_reg))
            begin
                last_send_next = tick_next;
                updated_next   = 1'b1;
                if (gap_reg)
                begin
                    duty_next = empty_code_reg;
                    gap_next  = 1'b0;
                end
                else if (pos_reg < count_ext)
                begin
                    duty_next = cur_bit ? dash_code_reg : dot_code_reg;
                    pos_next  = pos_reg + POS_W'(1);
                    gap_next  = 1'b1;
                end
                else if (pos_reg == count_ext)
                begin
                    duty_next = end_code_reg;
                    pos_next  = pos_reg + POS_W'(1);
                end
                else
                begin
                    // Drop the line and clear the store.
                    duty_next    = DUTY_OFF;
                    bits_next    = '0;
                    count_next   = '0;
                    sending_next = 1'b0;
                end
            end
        end

        out_valid_next = accept || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            press_reg     <= '0;
            release_reg   <= '0;
            last_send_reg <= '0;
            key_down_reg  <= 1'b0;
            bits_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            sending_reg   <= 1'b0;
            gap_reg       <= 1'b0;
            duty_reg      <= DUTY_OFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                tick_reg      <= tick_next;
                press_reg     <= press_next;
                release_reg   <= release_next;
                last_send_reg <= last_send_next;
                key_down_reg  <= key_down_next;
                bits_reg      <= bits_next;
                count_reg     <= count_next;
                pos_reg       <= pos_next;
                sending_reg   <= sending_next;
                gap_reg       <= gap_next;
                duty_reg      <= duty_next;
            end
        end
    end

    // Result payload: load on accept only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_duty_reg <= duty_next;
            res_upd_reg  <= updated_next;
            res_busy_reg <= sending_next;
            res_held_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_value   = res_duty_reg;
    assign duty_updated = res_upd_reg;
    assign busy_sending = res_busy_reg;
    assign symbols_held = HELD_W'(res_held_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MKPWT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_SYMBOLS))
    `MKPWT_ASSERT_IMPLY(a_gap_in_frame, clk, rst_n, !sending_reg, !gap_reg)
    `MKPWT_ASSERT_IMPLY(a_pos_bound, clk, rst_n, sending_reg, pos_reg <= POS_W'(count_reg) + POS_W'(1))

endmodule

// ===== tb/sv/morse_key_pulse_width_transmitter_tb.sv =====
module morse_key_pulse_width_transmitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mkpwt_pkg::*;

    localparam int MAX_SYM = 16;

    // Expected content of one result word.
    typedef struct {
        duty_t             duty;
        logic              updated;
        logic              busy;
        logic [HELD_W-1:0] held;
    } tick_word_t;

    // Local copy of the register file.
    typedef struct {
        ms_t   dot_max;
        ms_t   idle_gap;
        ms_t   sym_period;
        duty_t start_code;
        duty_t dot_code;
        duty_t dash_code;
        duty_t end_code;
        duty_t empty_code;
    } keyer_cfg_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  button_pressed = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DUTY_W-1:0]     duty_value;
    logic                  duty_updated;
    logic                  busy_sending;
    logic [HELD_W-1:0]     symbols_held;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    morse_key_pulse_width_transmitter #(.MAX_SYMBOLS(MAX_SYM)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duty_value     (duty_value),
        .duty_updated   (duty_updated),
        .busy_sending   (busy_sending),
        .symbols_held   (symbols_held),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Keyer state as the testbench sees it; advanced once per accepted word
    // ------------------------------------------------------------------
    keyer_cfg_t           cfg_now;
    time_t                tick_cnt;
    time_t                press_at;
    time_t                release_at;
    time_t                last_emit_at;
    bit                   key_dn;
    bit                   in_frame;
    bit                   sep_due;
    logic [MAX_SYM-1:0]   sym_bits;
    int                   sym_cnt;
    int                   emit_pos;
    duty_t                duty_now;

    tick_word_t           pending_words[$];

    // Knobs for the idling phases, in percent.
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    int                   errors = 0;
    int                   ticks_sent = 0;
    int                   words_checked = 0;
    int                   frames_sent = 0;
    int                   symbols_dropped = 0;
    int                   rewrites_seen = 0;

    task automatic reset_keyer();
        cfg_now = '{RST_DOT_MAX, RST_IDLE_GAP, RST_SYM_PER, RST_START,
                    RST_DOT_CODE, RST_DASH_CODE, RST_END_CODE, RST_EMPTY};
        tick_cnt     = '0;
        press_at     = '0;
        release_at   = '0;
        last_emit_at = '0;
        key_dn       = 1'b0;
        in_frame     = 1'b0;
        sep_due      = 1'b0;
        sym_bits     = '0;
        sym_cnt      = 0;
        emit_pos     = 0;
        duty_now     = DUTY_OFF;
    endtask

    // Work out the result word that one millisecond tick produces, and queue it.
    task automatic step_keyer(input logic pressed);
        time_t      held;
        logic       upd;
        tick_word_t w;
        upd = 1'b0;
        tick_cnt = tick_cnt + 1;

        // Classify a press on its release; drop it once the store is full.
        if (pressed && !key_dn) begin
            key_dn   = 1'b1;
            press_at = tick_cnt;
        end else if (!pressed && key_dn) begin
            key_dn     = 1'b0;
            release_at = tick_cnt;
            held       = release_at - press_at;
            if (sym_cnt < MAX_SYM) begin
                sym_bits = {sym_bits[MAX_SYM-2:0], held > time_t'(cfg_now.dot_max)};
                sym_cnt++;
            end else begin
                symbols_dropped++;
            end
        end

        // Open a frame after the idle gap, then pace the duty updates.
        if (sym_cnt > 0 && !in_frame) begin
            if (time_t'(tick_cnt - release_at) >= time_t'(cfg_now.idle_gap)) begin
                in_frame     = 1'b1;
                emit_pos     = 0;
                duty_now     = cfg_now.start_code;
                upd          = 1'b1;
                last_emit_at = tick_cnt;
            end
        end else if (in_frame) begin
            if (time_t'(tick_cnt - last_emit_at) >= time_t'(cfg_now.sym_period)) begin
                last_emit_at = tick_cnt;
                upd          = 1'b1;
                if (sep_due) begin
                    duty_now = cfg_now.empty_code;
                    sep_due  = 1'b0;
                end else if (emit_pos < sym_cnt) begin
                    duty_now = sym_bits[sym_cnt - emit_pos - 1] ? cfg_now.dash_code
                                                                : cfg_now.dot_code;
                    emit_pos++;
                    sep_due = 1'b1;
                end else if (emit_pos == sym_cnt) begin
                    duty_now = cfg_now.end_code;
                    emit_pos++;
                end else begin
                    duty_now = DUTY_OFF;
                    sym_bits = '0;
                    sym_cnt  = 0;
                    in_frame = 1'b0;
                    frames_sent++;
                end
            end
        end

        w.duty    = duty_now;
        w.updated = upd;
        w.busy    = in_frame;
        w.held    = HELD_W'(sym_cnt);
        pending_words.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random, and check every word taken off the port
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, fname, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        tick_word_t w;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t ns: result word with nothing expected, expected none actual %0d",
                         $time, duty_value);
            end else begin
                w = pending_words.pop_front();
                check_field("duty_value", w.duty, duty_value);
                check_field("duty_updated", 8'(w.updated), 8'(duty_updated));
                check_field("busy_sending", 8'(w.busy), 8'(busy_sending));
                check_field("symbols_held", 8'(w.held), 8'(symbols_held));
                words_checked++;
                if (duty_updated === 1'b1)
                    rewrites_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one tick word; idle first at the phase's rate, with noise on the
    // key line while valid is low. Leave valid high afterwards so that
    // back-to-back words keep it asserted.
    task automatic send_tick(input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid       <= 1'b0;
            button_pressed <= 1'($urandom);
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        button_pressed <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_keyer(lvl);
        ticks_sent++;
    endtask

    // Hold the key for hold_ticks, then leave it up for rest_ticks.
    task automatic press(input int hold_ticks, input int rest_ticks);
        repeat (hold_ticks) send_tick(1'b1);
        repeat (rest_ticks) send_tick(1'b0);
    endtask

    // Keep the key up until the store is empty and no frame is running.
    task automatic run_until_quiet();
        do
            send_tick(1'b0);
        while (sym_cnt != 0 || in_frame);
    endtask

    // Drop valid and wait for every expected word to come out.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write the whole register file while the block is idle. Code registers
    // get junk in the upper byte, which the block must ignore.
    task automatic write_regs(input keyer_cfg_t c);
        cfg_idx_t  idx[8];
        cfg_data_t val[8];
        logic [7:0] pad;
        wait_all_results();
        pad = 8'($urandom);
        idx = '{REG_DOT_MAX, REG_IDLE_GAP, REG_SYM_PER, REG_START,
                REG_DOT_CODE, REG_DASH_CODE, REG_END_CODE, REG_EMPTY};
        val = '{c.dot_max, c.idle_gap, c.sym_period, {pad, c.start_code},
                {~pad, c.dot_code}, {pad, c.dash_code}, {~pad, c.end_code},
                {pad, c.empty_code}};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        cfg_now = c;
    endtask

    function automatic keyer_cfg_t random_cfg(input int dot_hi, input int gap_hi,
                                              input int per_hi);
        keyer_cfg_t c;
        c.dot_max    = ms_t'($urandom_range(dot_hi));
        c.idle_gap   = ms_t'($urandom_range(gap_hi));
        c.sym_period = ms_t'($urandom_range(per_hi, 1));
        c.start_code = duty_t'($urandom);
        c.dot_code   = duty_t'($urandom);
        c.dash_code  = duty_t'($urandom);
        c.end_code   = duty_t'($urandom);
        c.empty_code = duty_t'($urandom);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the long default gap holds a fresh dot in the store.
    task automatic test_defaults_hold();
        press(1, 3);
    endtask

    // Short gap: dots and dashes either side of the dot limit, then one full frame.
    task automatic test_dot_and_dash();
        keyer_cfg_t c;
        c = random_cfg(0, 0, 1);
        c.dot_max  = 16'd2;
        c.idle_gap = 16'd4;
        write_regs(c);
        press(1, 1);
        press(2, 1);
        press(3, 1);
        run_until_quiet();
    endtask

    // Zero gap opens the frame on the release tick; zero period updates every
    // tick. Presses during the frame still land in the store.
    task automatic test_zero_gap_and_period();
        keyer_cfg_t c;
        c = '{16'd1, 16'd0, 16'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        write_regs(c);
        press(1, 1);
        press(3, 1);
        press(1, 2);
        run_until_quiet();
    endtask

    // Overfill the store: the seventeenth symbol onwards is dropped.
    task automatic test_store_full();
        keyer_cfg_t c;
        c = random_cfg(0, 0, 1);
        c.dot_max  = 16'd3;
        c.idle_gap = 16'd50;
        write_regs(c);
        repeat (MAX_SYM + 2) press($urandom_range(6, 1), $urandom_range(3, 1));
        run_until_quiet();
    endtask

    // Register extremes: every press a dash, every press a dot, a gap that
    // never runs out, and a period so long the frame stalls after its start.
    task automatic test_register_extremes();
        keyer_cfg_t c;
        c = '{16'd0, 16'hFFFF, 16'd1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        write_regs(c);
        press(1, 1);
        press(2, 3);
        c.dot_max = 16'hFFFF;
        write_regs(c);
        press(4, 2);
        c.idle_gap   = 16'd1;
        c.sym_period = 16'hFFFF;
        write_regs(c);
        repeat (4) send_tick(1'b0);
        c.sym_period = 16'd1;
        write_regs(c);
        run_until_quiet();
    endtask

    // Random keying in four idling phases. Mostly well-formed presses around
    // the dot limit with gaps either side of the idle gap; the rest is noise
    // and long holds.
    task automatic test_random_keying();
        int idle_pct[4];
        int stall_pct[4];
        int start;
        bit paused;
        keyer_cfg_t c;
        idle_pct  = '{0, 71, 0, 16};
        stall_pct = '{0, 0, 71, 16};
        for (int ph = 0; ph < 4; ph++) begin
            c = random_cfg(5, 12, 3);
            write_regs(c);
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            start  = ticks_sent;
            paused = 1'b0;
            while (ticks_sent - start < 70) begin
                // Hold off once mid-phase until the pipeline has emptied.
                if (!paused && ticks_sent - start >= 35) begin
                    wait_all_results();
                    paused = 1'b1;
                end
                case ($urandom_range(19))
                    0, 1: repeat ($urandom_range(6, 1)) send_tick(1'($urandom));
                    2:    press($urandom_range(30, 5), $urandom_range(3, 1));
                    default:
                        press($urandom_range(c.dot_max + 3, 1),
                              ($urandom_range(3) == 0) ? c.idle_gap + $urandom_range(8, 1)
                                                       : $urandom_range(4, 1));
                endcase
            end
            run_until_quiet();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_keyer();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_hold();
        test_dot_and_dash();
        test_zero_gap_and_period();
        test_store_full();
        test_register_extremes();
        test_random_keying();

        // Drain, then keep watching for any stray word to show up.
        wait_all_results();
        repeat (4) @(posedge clk);

        $display("Sent %0d ticks, checked %0d result words, %0d duty rewrites",
                 ticks_sent, words_checked, rewrites_seen);
        $display("Frames completed: %0d; symbols dropped on a full store: %0d",
                 frames_sent, symbols_dropped);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("Timed out with %0d words still expected", pending_words.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
